FILE: src/pngu_pkg.sv
`timescale 1ns / 1ps
package pngu_pkg;

  localparam int MAX_ROW_PIXELS  = 4096;
  localparam int BYTES_PER_PIXEL = 3;
  localparam int LINE_BYTES      = MAX_ROW_PIXELS * BYTES_PER_PIXEL;
  localparam int POS_W           = $clog2(LINE_BYTES);
  localparam int PIX_W           = 13;
  localparam int SLOT_W          = 2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam logic [7:0] LAST_FILTER_CODE = 8'(FILT_PAETH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } out_t;

  // Paeth predictor: pick the neighbor closest to a + b - c, ties go a, then b.
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [7:0] pa;
    logic [7:0] pb;
    logic [8:0] ab;
    logic [8:0] c2;
    logic [8:0] pc;
    logic [7:0] res;
    pa = (b > c) ? b - c : c - b;
    pb = (a > c) ? a - c : c - a;
    ab = {1'b0, a} + {1'b0, b};
    c2 = {c, 1'b0};
    pc = (ab > c2) ? ab - c2 : c2 - ab;
    if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
      res = a;
    end else if ({1'b0, pb} <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

FILE: src/png_scanline_unfilter_rgb8.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload  Handshake
// in        input      in_t     in_valid / in_stall
// out       output     out_t    out_valid / out_stall
// cfg       input      13 bits  cfg_we (row_pixels)
//
// One byte per cycle while in_stall is low; a taken sample byte goes through s1 to
// the result register. Only samples and bad filter codes give an output beat.
// Reset (rst, synchronous) clears control state; the line buffer is not cleared.
// A stalled output holds the result register, and the input stalls only when
// the middle stage is also full.
module png_scanline_unfilter_rgb8 (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pngu_pkg::in_t          in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pngu_pkg::out_t         out_data,
  input  logic                   cfg_we,
  input  logic [12:0]            cfg_data
);
  import pngu_pkg::*;

  // Configuration
  logic [POS_W-1:0] row_len;
  logic [PIX_W-1:0] pix_clamped;

  // Row control state
  logic             expect_filter;
  logic             first_row;
  logic             halted;
  filt_t            row_filter;
  logic [POS_W-1:0] pos;
  logic [SLOT_W-1:0] slot;

  // Neighbor bytes per color slot
  logic [7:0] left_bytes [BYTES_PER_PIXEL];
  logic [7:0] upper_left_bytes [BYTES_PER_PIXEL];

  // Line buffer
  logic [7:0] line_mem [LINE_BYTES];
  logic [7:0] above;

  // Middle stage
  logic             s1_valid;
  logic             s1_err;
  logic             s1_first;
  logic             s1_last;
  filt_t            s1_filter;
  logic [POS_W-1:0] s1_pos;
  logic [SLOT_W-1:0] s1_slot;
  logic [7:0]       s1_byte;

  logic advance;
  logic in_acc;
  logic s1_load;

  logic start;
  logic halted_eff;
  logic expect_eff;
  logic first_eff;
  logic bad_code;
  logic is_sample;
  logic is_err;
  logic is_filter;
  logic clear_nb;
  logic last;
  logic [POS_W:0] pos_inc;

  logic [7:0] a_byte;
  logic [7:0] b_byte;
  logic [7:0] c_byte;
  logic [8:0] ab_sum;
  logic [7:0] pred;
  logic [7:0] x_byte;
  logic       s1_write;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign s1_load  = !in_stall;
  assign in_acc   = in_valid && !in_stall;

  // Decode of the byte being taken, against the state it finds.
  assign start      = in_data.image_start;
  assign halted_eff = halted && !start;
  assign expect_eff = expect_filter || start;
  assign first_eff  = first_row || start;
  assign bad_code   = in_data.in_byte > LAST_FILTER_CODE;
  assign is_err     = in_acc && !halted_eff && expect_eff && bad_code;
  assign is_filter  = in_acc && !halted_eff && expect_eff && !bad_code;
  assign is_sample  = in_acc && !halted_eff && !expect_eff;
  assign clear_nb   = in_acc && (start || is_filter);
  assign pos_inc    = {1'b0, pos} + 1'b1;
  assign last       = pos_inc >= {1'b0, row_len};

  always_comb begin
    pix_clamped = cfg_data;
    if (cfg_data == '0) begin
      pix_clamped = PIX_W'(1);
    end else if (cfg_data > PIX_W'(MAX_ROW_PIXELS)) begin
      pix_clamped = PIX_W'(MAX_ROW_PIXELS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len <= POS_W'(BYTES_PER_PIXEL);
    end else if (cfg_we) begin
      row_len <= POS_W'({pix_clamped, 1'b0}) + POS_W'(pix_clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_filter <= 1'b1;
      first_row     <= 1'b1;
      halted        <= 1'b0;
      row_filter    <= FILT_NONE;
      pos           <= '0;
      slot          <= '0;
    end else if (in_acc) begin
      if (start) begin
        expect_filter <= 1'b1;
        first_row     <= 1'b1;
        halted        <= 1'b0;
      end
      if (is_err) begin
        halted <= 1'b1;
      end else if (is_filter) begin
        row_filter    <= filt_t'(in_data.in_byte[2:0]);
        expect_filter <= 1'b0;
        pos           <= '0;
        slot          <= '0;
      end else if (is_sample) begin
        if (last) begin
          expect_filter <= 1'b1;
          first_row     <= 1'b0;
        end else begin
          pos  <= pos_inc[POS_W-1:0];
          slot <= (slot == SLOT_W'(BYTES_PER_PIXEL - 1)) ? '0 : slot + 1'b1;
        end
      end
    end
  end

  // The read for a sample is issued as it is taken; its data lines up with s1.
  always_ff @(posedge clk) begin
    if (is_sample) begin
      above <= line_mem[pos];
    end
    if (s1_write) begin
      line_mem[s1_pos] <= x_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= is_sample || is_err;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_err    <= is_err;
      s1_first  <= first_eff;
      s1_last   <= last;
      s1_filter <= row_filter;
      s1_pos    <= pos;
      s1_slot   <= slot;
      s1_byte   <= in_data.in_byte;
    end
  end

  // Reconstruction
  assign a_byte = left_bytes[s1_slot];
  assign b_byte = s1_first ? 8'd0 : above;
  assign c_byte = s1_first ? 8'd0 : upper_left_bytes[s1_slot];
  assign ab_sum = {1'b0, a_byte} + {1'b0, b_byte};

  always_comb begin
    case (s1_filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a_byte;
      FILT_UP:    pred = b_byte;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a_byte, b_byte, c_byte);
      default:    pred = 8'd0;
    endcase
  end

  assign x_byte   = s1_byte + pred;
  assign s1_write = s1_valid && advance && !s1_err;

  // A clear from a newly taken filter or start byte comes after the sample
  // leaving s1 in stream order, so it wins.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
        left_bytes[i]       <= 8'd0;
        upper_left_bytes[i] <= 8'd0;
      end
    end else if (clear_nb) begin
      for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
        left_bytes[i]       <= 8'd0;
        upper_left_bytes[i] <= 8'd0;
      end
    end else if (s1_write) begin
      left_bytes[s1_slot]       <= x_byte;
      upper_left_bytes[s1_slot] <= b_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data.pixel_byte <= s1_err ? 8'd0 : x_byte;
      out_data.row_end    <= s1_err ? 1'b0 : s1_last;
      out_data.bad_filter <= s1_err;
    end
  end

endmodule

FILE: src/pngu_checker.sv
`timescale 1ns / 1ps
module pngu_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input pngu_pkg::out_t out_data
);
  import pngu_pkg::*;

  // A held output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_filter |-> out_data.pixel_byte == 8'd0 && !out_data.row_end)
    else $error("error beat carries sample fields");

  // The input side only backs up when the output is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind png_scanline_unfilter_rgb8 pngu_checker u_pngu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/tb_png_scanline_unfilter_rgb8.sv
`timescale 1ns / 1ps
module tb_png_scanline_unfilter_rgb8;
  import pngu_pkg::*;

  localparam int HOLD_CYCLES   = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 800;
  localparam int SETTLE_CYCLES = 4;

  class unfilter_scoreboard;
    logic [7:0]  prev_line [LINE_BYTES];
    logic [7:0]  left_px [BYTES_PER_PIXEL];
    logic [7:0]  upper_left_px [BYTES_PER_PIXEL];
    int          col;
    filt_t       filt;
    bit          top_row;
    bit          halted;
    logic [12:0] row_px;
    int          written_bytes;
    out_t        expected_pixels [$];
    int          mismatches;

    function new();
      foreach (prev_line[i]) prev_line[i] = '0;
      clear_neighbors();
      col = 0;
      filt = FILT_NONE;
      top_row = 1'b1;
      halted = 1'b0;
      row_px = 13'd1;
      written_bytes = 0;
      mismatches = 0;
    endfunction

    function void clear_neighbors();
      foreach (left_px[i]) begin
        left_px[i] = '0;
        upper_left_px[i] = '0;
      end
    endfunction

    function int pixels_for(logic [12:0] v);
      if (v == 0) return 1;
      if (v > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
      return int'(v);
    endfunction

    // The line buffer is never cleared, so a row below the first may only
    // reach as far as some earlier row has already written.
    function bit widen_ok(logic [12:0] v);
      return top_row || (pixels_for(v) * BYTES_PER_PIXEL <= written_bytes);
    endfunction

    function int samples_left();
      int n;
      if (col == 0) return 0;
      n = pixels_for(row_px) * BYTES_PER_PIXEL - (col - 1);
      return (n < 1) ? 1 : n;
    endfunction

    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int pa;
      int pb;
      int pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      else if (pb <= pc) return b;
      else return c;
    endfunction

    // Returns 0 when the byte is dropped because the stream is halted.
    function bit take_stream_byte(in_t beat);
      int         p;
      int         slot;
      int         len;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] pred;
      logic [7:0] x;
      out_t       want;
      if (beat.image_start) begin
        col = 0;
        top_row = 1'b1;
        halted = 1'b0;
        clear_neighbors();
      end
      if (halted) return 1'b0;
      if (col == 0) begin
        if (beat.in_byte > LAST_FILTER_CODE) begin
          halted = 1'b1;
          want.pixel_byte = '0;
          want.row_end = 1'b0;
          want.bad_filter = 1'b1;
          expected_pixels.push_back(want);
        end else begin
          filt = filt_t'(beat.in_byte[2:0]);
          col = 1;
          clear_neighbors();
        end
        return 1'b1;
      end
      len = pixels_for(row_px) * BYTES_PER_PIXEL;
      p = col - 1;
      if (p >= LINE_BYTES) p = LINE_BYTES - 1;
      slot = p % BYTES_PER_PIXEL;
      a = left_px[slot];
      b = top_row ? 8'd0 : prev_line[p];
      c = top_row ? 8'd0 : upper_left_px[slot];
      case (filt)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = '0;
      endcase
      x = beat.in_byte + pred;
      left_px[slot] = x;
      upper_left_px[slot] = b;
      prev_line[p] = x;
      if (p + 1 > written_bytes) written_bytes = p + 1;
      want.pixel_byte = x;
      want.bad_filter = 1'b0;
      want.row_end = (p + 1 >= len);
      if (want.row_end) begin
        col = 0;
        top_row = 1'b0;
      end else begin
        col = p + 2;
      end
      expected_pixels.push_back(want);
      return 1'b1;
    endfunction

    task flag_mismatch(string what);
      if (mismatches < 40) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_pixel(out_t got);
      out_t want;
      if (expected_pixels.size() == 0) begin
        flag_mismatch($sformatf("output beat %h with nothing expected", got));
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_byte !== want.pixel_byte)
          flag_mismatch($sformatf("pixel_byte %h, expected %h", got.pixel_byte,
                                  want.pixel_byte));
        if (got.row_end !== want.row_end)
          flag_mismatch($sformatf("row_end %b, expected %b", got.row_end, want.row_end));
        if (got.bad_filter !== want.bad_filter)
          flag_mismatch($sformatf("bad_filter %b, expected %b", got.bad_filter,
                                  want.bad_filter));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic [12:0] cfg_data;

  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;
  int                 useful_items = 0;
  int                 quiet_cycles = 0;
  unfilter_scoreboard sb;

  png_scanline_unfilter_rgb8 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  task send_beat(input logic [7:0] b, input bit st);
    in_t beat;
    int  gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 13) gap = $urandom_range(1, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    beat.in_byte = b;
    beat.image_start = st;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    if (sb.take_stream_byte(beat)) useful_items++;
  endtask

  task send_one_pixel_row(input filt_t f, input bit st, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] bl);
    send_beat(8'(f), st);
    send_beat(r, 1'b0);
    send_beat(g, 1'b0);
    send_beat(bl, 1'b0);
  endtask

  // Stop offering beats and wait until every expected beat has come out.
  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_width(input logic [12:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    sb.row_px = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task run_phase(input logic [12:0] width_val, input int rows, input bit hold);
    bit fresh;
    int r;
    int len;
    fresh = 1'b1;
    drain();
    // Sometimes carry on with the current image, possibly in the middle of a row.
    if (!sb.halted && sb.widen_ok(width_val) && $urandom_range(0, 2) == 0) fresh = 1'b0;
    set_width(width_val);
    if (hold) hold_req = 1'b1;
    if (!fresh) repeat (sb.samples_left()) send_beat(pick_sample(), 1'b0);
    repeat (rows) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_beat(8'($urandom_range(5, 255)), fresh);
        repeat ($urandom_range(0, 3)) send_beat(8'($urandom), 1'b0);
        fresh = 1'b1;
      end else begin
        send_beat(8'($urandom_range(0, 4)), fresh);
        fresh = 1'b0;
        len = sb.samples_left();
        if (r < 8) begin
          // Broken row: the row is cut short, and the next beat of this phase starts a new image.
          repeat ($urandom_range(0, len - 1)) send_beat(pick_sample(), 1'b0);
          fresh = 1'b1;
        end else begin
          repeat (len) send_beat(pick_sample(), 1'b0);
        end
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      send_beat(8'($urandom_range(0, 4)), fresh);
      repeat ($urandom_range(0, sb.samples_left() - 1)) send_beat(pick_sample(), 1'b0);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // Long hold-off so the pipeline fills and the input side backs up.
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int          random_goal;
    int          phase;
    int          rows;
    bit          hold;
    logic [12:0] width_val;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A zero row length is taken as one pixel, so each row below is 3 samples.
    set_width(13'd0);
    send_one_pixel_row(FILT_NONE, 1'b1, 8'h00, 8'hFF, 8'h80);
    send_one_pixel_row(FILT_SUB, 1'b0, 8'hFF, 8'h01, 8'h7F);
    send_one_pixel_row(FILT_UP, 1'b0, 8'h01, 8'hFF, 8'h00);
    send_one_pixel_row(FILT_AVG, 1'b0, 8'hFF, 8'hFF, 8'h81);
    send_one_pixel_row(FILT_PAETH, 1'b0, 8'h10, 8'hF0, 8'h00);
    // Smallest bad filter code, a dropped byte, then a bad code on image start.
    send_beat(8'(LAST_FILTER_CODE) + 8'd1, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_one_pixel_row(FILT_PAETH, 1'b1, 8'h33, 8'h44, 8'h55);

    random_goal = useful_items + RANDOM_ITEMS;
    phase = 0;
    while (useful_items < random_goal) begin
      hold = (phase == 2 || phase == 12);
      calm = hold || (phase >= 5 && phase < 12);
      if (hold) begin
        width_val = 13'd10;
        rows = 3;
      end else begin
        case ($urandom_range(0, 19))
          0: width_val = 13'd0;
          1: width_val = 13'($urandom_range(7, 40));
          default: width_val = 13'($urandom_range(1, 6));
        endcase
        rows = $urandom_range(1, 6);
      end
      run_phase(width_val, rows, hold);
      phase++;
    end

    // A value beyond the maximum row length: the row runs on past every short
    // length, is broken off, and the next phase may shorten it mid-row.
    calm = 1'b0;
    drain();
    set_width(13'd8191);
    send_beat(8'(FILT_SUB), 1'b1);
    repeat (24) send_beat(pick_sample(), 1'b0);
    run_phase(13'd3, 3, 1'b0);
    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pngu_pkg.sv
src/png_scanline_unfilter_rgb8.sv
src/pngu_checker.sv
tb/tb_png_scanline_unfilter_rgb8.sv
